/* rtl/core/lisp_char_tokenizer_top_defines.svh */
// Assertion macros for the tokenizer core.
// Define NO_ASSERTIONS to compile them away.
`ifndef LISP_CHAR_TOKENIZER_TOP_DEFINES_SVH
`define LISP_CHAR_TOKENIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset.
`define LCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lct assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lct assertion failed");

`else

`define LCT_ASSERT_NOW(label, ante, cons)
`define LCT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/lct_pkg.sv */
package lct_pkg;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_END  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_TOKEN  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        TK_NOP  = 3'd0,
        TK_CALL = 3'd1,
        TK_END  = 3'd2,
        TK_STR  = 3'd3,
        TK_NUM  = 3'd4,
        TK_ID   = 3'd5,
        TK_EOF  = 3'd6
    } tok_kind_t;

    typedef enum logic {
        ERR_BACKSLASH = 1'b0,
        ERR_ESCAPED   = 1'b1
    } err_code_t;

    // One result beat.
    typedef struct packed {
        kind_t       kind;
        tok_kind_t   token_kind;
        logic [7:0]  char_out;
        err_code_t   error_code;
        logic        last_of_run;
    } lct_res_t;

    // Lexer state carried between characters.
    typedef struct packed {
        logic       line_comment;
        logic       block_comment;
        logic       single_quote;
        logic       double_quote;
        logic       escape_pending;
        tok_kind_t  current_kind;
        logic [7:0] prev_char;
        logic       has_prev;
    } lct_state_t;

    // Result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

/* rtl/core/lct_decode.sv */
module lct_decode (
    input  lct_pkg::lct_state_t state,
    input  lct_pkg::opcode_t    opcode,
    input  logic [7:0]          char_in,
    output lct_pkg::lct_state_t state_next,
    output lct_pkg::lct_res_t   res0,
    output lct_pkg::lct_res_t   res1,
    output logic [1:0]          res_cnt
);
    import lct_pkg::*;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    function automatic lct_res_t mk_app(input logic [7:0] c);
        lct_res_t r;
        r = '0;
        r.kind     = KIND_APPEND;
        r.char_out = c;
        return r;
    endfunction

    function automatic lct_res_t mk_tok(input tok_kind_t tk);
        lct_res_t r;
        r = '0;
        r.kind       = KIND_TOKEN;
        r.token_kind = tk;
        return r;
    endfunction

    function automatic lct_res_t mk_err(input err_code_t e);
        lct_res_t r;
        r = '0;
        r.kind       = KIND_ERROR;
        r.error_code = e;
        return r;
    endfunction

    logic     cmt;
    logic     quo;
    lct_res_t r0;
    lct_res_t r1;
    logic [1:0] n;

    assign cmt = state.line_comment | state.block_comment;
    assign quo = state.single_quote | state.double_quote;

    always_comb
    begin
        state_next = state;
        r0 = '0;
        r1 = '0;
        n  = 2'd0;
        if (opcode == OP_END)
        begin
            r0 = mk_tok(state.current_kind);
            r1 = mk_tok(TK_EOF);
            n  = 2'd2;
            state_next = '0;
        end
        else
        begin
            if (state.escape_pending)
            begin
                r0 = quo ? mk_app(char_in) : mk_err(ERR_ESCAPED);
                n  = 2'd1;
                state_next.escape_pending = 1'b0;
            end
            else
            begin
                case (char_in)
                    CH_LPAREN, CH_RPAREN:
                    begin
                        if (!cmt)
                        begin
                            if (quo)
                            begin
                                r0 = mk_app(char_in);
                                n  = 2'd1;
                            end
                            else
                            begin
                                r0 = mk_tok(state.current_kind);
                                r1 = mk_tok((char_in == CH_LPAREN) ? TK_CALL : TK_END);
                                n  = 2'd2;
                                state_next.current_kind = TK_NOP;
                            end
                        end
                    end
                    CH_TAB, CH_SPACE:
                    begin
                        if (!cmt)
                        begin
                            if (state.single_quote)
                            begin
                                state_next.single_quote = 1'b0;
                                r0 = mk_tok(state.current_kind);
                                n  = 2'd1;
                                state_next.current_kind = TK_NOP;
                            end
                            else if (state.double_quote)
                            begin
                                r0 = mk_app(char_in);
                                n  = 2'd1;
                            end
                            else if (char_in == CH_SPACE)
                            begin
                                r0 = mk_tok(state.current_kind);
                                n  = 2'd1;
                                state_next.current_kind = TK_NOP;
                            end
                        end
                    end
                    CH_NL:
                    begin
                        if (state.line_comment)
                            state_next.line_comment = 1'b0;
                        else if (state.single_quote)
                        begin
                            state_next.single_quote = 1'b0;
                            r0 = mk_tok(state.current_kind);
                            n  = 2'd1;
                            state_next.current_kind = TK_NOP;
                        end
                        else if (state.double_quote)
                        begin
                            r0 = mk_app(char_in);
                            n  = 2'd1;
                        end
                    end
                    CH_BSLASH:
                    begin
                        if (!quo && !cmt)
                        begin
                            r0 = mk_err(ERR_BACKSLASH);
                            n  = 2'd1;
                        end
                        else
                            state_next.escape_pending = 1'b1;
                    end
                    CH_DQUOTE:
                    begin
                        if (!cmt)
                        begin
                            if (state.double_quote)
                            begin
                                state_next.double_quote = 1'b0;
                                r0 = mk_tok(state.current_kind);
                                n  = 2'd1;
                                state_next.current_kind = TK_NOP;
                            end
                            else if (state.single_quote)
                            begin
                                r0 = mk_app(char_in);
                                n  = 2'd1;
                            end
                            else
                            begin
                                r0 = mk_tok(state.current_kind);
                                n  = 2'd1;
                                state_next.current_kind = TK_STR;
                                state_next.double_quote = 1'b1;
                            end
                        end
                    end
                    CH_SQUOTE:
                    begin
                        if (!cmt)
                        begin
                            if (state.single_quote)
                            begin
                                state_next.single_quote = 1'b0;
                                r0 = mk_tok(state.current_kind);
                                n  = 2'd1;
                                state_next.current_kind = TK_NOP;
                            end
                            else if (state.double_quote)
                            begin
                                r0 = mk_app(char_in);
                                n  = 2'd1;
                            end
                            else
                            begin
                                state_next.current_kind = TK_STR;
                                state_next.single_quote = 1'b1;
                            end
                        end
                    end
                    CH_SEMI:
                    begin
                        if (!cmt)
                        begin
                            if (quo)
                            begin
                                r0 = mk_app(char_in);
                                n  = 2'd1;
                            end
                            else
                                state_next.line_comment = 1'b1;
                        end
                    end
                    CH_BAR:
                    begin
                        if (quo)
                        begin
                            r0 = mk_app(char_in);
                            n  = 2'd1;
                        end
                        if (state.has_prev && state.prev_char == CH_HASH)
                            state_next.block_comment = 1'b1;
                    end
                    CH_HASH:
                    begin
                        if (quo)
                        begin
                            r0 = mk_app(char_in);
                            n  = 2'd1;
                        end
                        if (state.has_prev && state.prev_char == CH_BAR)
                            state_next.block_comment = 1'b0;
                    end
                    default:
                    begin
                        if (!cmt)
                        begin
                            if (char_in inside {[CH_ZERO:CH_NINE]})
                                state_next.current_kind = TK_NUM;
                            else if (!quo)
                                state_next.current_kind = TK_ID;
                            r0 = mk_app(char_in);
                            n  = 2'd1;
                        end
                    end
                endcase
            end
            state_next.prev_char = char_in;
            state_next.has_prev  = 1'b1;
        end
        // flag the final beat of this item
        if (n == 2'd1)
            r0.last_of_run = 1'b1;
        if (n == 2'd2)
            r1.last_of_run = 1'b1;
    end

    assign res0    = r0;
    assign res1    = r1;
    assign res_cnt = n;

endmodule

/* rtl/core/lisp_char_tokenizer_top.sv */
// With the queue empty, an item's first beat is on the output port in the cycle after
// acceptance and its second beat once the first is taken. Throughput: 1 item per cycle while
// in_stall is low; each item makes 0 to 2 beats, drained 1 beat per cycle while out_stall is low
// through a 4-entry result queue; input stalls while the queue holds more than 2 beats.
// Reset (rst_n low, asynchronous): all lexer flags, token kind and previous
// character clear, and the result queue empties.
`include "lisp_char_tokenizer_top_defines.svh"

module lisp_char_tokenizer_top (
    input  logic       clk,
    input  logic       rst_n,

    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] char_in,

    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [2:0] token_kind,
    output logic [7:0] char_out,
    output logic       error_code,
    output logic       last_of_run
);
    import lct_pkg::*;

    // Lexer state: updated once per accepted item, from the decode logic.
    lct_state_t state_reg;
    lct_state_t state_next;

    // Up to two beats per item, pushed into the queue together on acceptance.
    lct_res_t   res0;
    lct_res_t   res1;
    logic [1:0] res_cnt;

    // Result queue: ring of registers, single read port at the head.
    lct_res_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;

    logic     in_fire;
    logic     out_fire;
    lct_res_t head;

    // Accept only while two free slots remain, so a double-beat item always fits.
    assign in_stall = (cnt_reg > QCNT_W'(QUEUE_DEPTH - 2));
    assign in_fire  = in_valid && !in_stall;

    lct_decode u_decode (
        .state      (state_reg),
        .opcode     (opcode_t'(opcode)),
        .char_in    (char_in),
        .state_next (state_next),
        .res0       (res0),
        .res1       (res1),
        .res_cnt    (res_cnt)
    );

    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && !out_stall;
    assign head      = queue_reg[rd_ptr_reg];

    assign kind        = head.kind;
    assign token_kind  = head.token_kind;
    assign char_out    = head.char_out;
    assign error_code  = head.error_code;
    assign last_of_run = head.last_of_run;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (in_fire)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(res_cnt);
            cnt_next    = cnt_next + QCNT_W'(res_cnt);
        end
        if (out_fire)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
            cnt_next    = cnt_next - QCNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (in_fire)
                state_reg <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue payload, no reset needed: entries are read only once counted.
    always_ff @(posedge clk)
    begin
        if (in_fire && res_cnt != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (in_fire && res_cnt == 2'd2)
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
    end

    // Queue never overfills.
    `LCT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    // A lone pop drops the fill count by exactly one beat.
    `LCT_ASSERT_NEXT(a_pop_only, out_fire && !in_fire, cnt_reg == $past(cnt_reg) - QCNT_W'(1))
    // End of source returns the lexer to its reset state.
    `LCT_ASSERT_NEXT(a_end_clears, in_fire && opcode == OP_END, state_reg == '0)
    // A pending escape only exists inside a quote or a comment.
    `LCT_ASSERT_NOW(a_esc_context, state_reg.escape_pending,
        state_reg.line_comment || state_reg.block_comment ||
        state_reg.single_quote || state_reg.double_quote)

endmodule

/* tb/lisp_char_tokenizer_top_test.sv */
module lisp_char_tokenizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lct_pkg::*;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int TOTAL_ITEMS   = 650;
    localparam int STALL_LIMIT   = 1000;  // cycles with no beat on either side
    localparam int LONG_HOLD     = 60;    // receiver hold-off that backs up the queue
    localparam int SETTLE_CYCLES = 8;     // quiet cycles after the last result
    localparam int MAX_REPORTS   = 100;

    // Character codes the lexer reacts to
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    localparam logic [7:0] SPECIALS [12] = '{CH_TAB, CH_NL, CH_SPACE, CH_DQUOTE, CH_HASH,
        CH_SQUOTE, CH_LPAREN, CH_RPAREN, CH_SEMI, CH_BSLASH, CH_BAR, CH_ZERO};

    typedef struct packed {
        opcode_t    op;
        logic [7:0] ch;
    } src_item_t;

    // ------------------------------------------------------------------
    // Lexer predictor and expected-beat store.
    // note_item runs the lexer on one accepted item and queues the beats
    // it must produce; check_beat pops the oldest one and compares.
    // ------------------------------------------------------------------
    class tokenizer_scoreboard;
        lct_res_t   expected_beats[$];
        lct_res_t   item_beats[$];
        int         failures;

        bit         in_line;
        bit         in_block;
        bit         in_squote;
        bit         in_dquote;
        bit         esc;
        tok_kind_t  cur_kind;
        logic [7:0] last_ch;
        bit         seen_ch;

        function new();
            failures = 0;
            clear_state();
        endfunction

        function void clear_state();
            in_line   = 1'b0;
            in_block  = 1'b0;
            in_squote = 1'b0;
            in_dquote = 1'b0;
            esc       = 1'b0;
            cur_kind  = TK_NOP;
            last_ch   = 8'h00;
            seen_ch   = 1'b0;
        endfunction

        function void push_beat(kind_t k, tok_kind_t tk, logic [7:0] c, err_code_t e);
            lct_res_t r;
            if (item_beats.size() >= 2)
                return;
            r.kind        = k;
            r.token_kind  = tk;
            r.char_out    = c;
            r.error_code  = e;
            r.last_of_run = 1'b0;
            item_beats.push_back(r);
        endfunction

        function void append(logic [7:0] c);
            push_beat(KIND_APPEND, TK_NOP, c, ERR_BACKSLASH);
        endfunction

        function void close_with(tok_kind_t tk);
            push_beat(KIND_TOKEN, tk, 8'h00, ERR_BACKSLASH);
            cur_kind = TK_NOP;
        endfunction

        function void lex_char(logic [7:0] c);
            bit in_cmt;
            bit in_quote;
            in_cmt   = in_line || in_block;
            in_quote = in_squote || in_dquote;

            // char after a backslash is taken raw
            if (esc) begin
                if (in_quote)
                    append(c);
                else
                    push_beat(KIND_ERROR, TK_NOP, 8'h00, ERR_ESCAPED);
                esc = 1'b0;
                return;
            end

            case (c)
                CH_LPAREN, CH_RPAREN: begin
                    if (!in_cmt) begin
                        if (in_quote) begin
                            append(c);
                        end else begin
                            close_with(cur_kind);
                            close_with(c == CH_LPAREN ? TK_CALL : TK_END);
                        end
                    end
                end
                CH_TAB, CH_SPACE: begin
                    if (!in_cmt) begin
                        if (in_squote) begin
                            in_squote = 1'b0;
                            close_with(cur_kind);
                        end else if (in_dquote) begin
                            append(c);
                        end else if (c == CH_SPACE) begin
                            close_with(cur_kind);
                        end
                    end
                end
                CH_NL: begin
                    if (in_line) begin
                        in_line = 1'b0;
                    end else if (in_squote) begin
                        in_squote = 1'b0;
                        close_with(cur_kind);
                    end else if (in_dquote) begin
                        append(c);
                    end
                end
                CH_BSLASH: begin
                    if (!in_quote && !in_cmt)
                        push_beat(KIND_ERROR, TK_NOP, 8'h00, ERR_BACKSLASH);
                    else
                        esc = 1'b1;
                end
                CH_DQUOTE: begin
                    if (!in_cmt) begin
                        if (in_dquote) begin
                            in_dquote = 1'b0;
                            close_with(cur_kind);
                        end else if (in_squote) begin
                            append(c);
                        end else begin
                            close_with(cur_kind);
                            cur_kind  = TK_STR;
                            in_dquote = 1'b1;
                        end
                    end
                end
                CH_SQUOTE: begin
                    if (!in_cmt) begin
                        if (in_squote) begin
                            in_squote = 1'b0;
                            close_with(cur_kind);
                        end else if (in_dquote) begin
                            append(c);
                        end else begin
                            cur_kind  = TK_STR;
                            in_squote = 1'b1;
                        end
                    end
                end
                CH_SEMI: begin
                    if (!in_cmt) begin
                        if (in_quote)
                            append(c);
                        else
                            in_line = 1'b1;
                    end
                end
                CH_BAR: begin
                    if (in_quote)
                        append(c);
                    if (seen_ch && last_ch == CH_HASH)
                        in_block = 1'b1;
                end
                CH_HASH: begin
                    if (in_quote)
                        append(c);
                    if (seen_ch && last_ch == CH_BAR)
                        in_block = 1'b0;
                end
                default: begin
                    if (!in_cmt) begin
                        if (c >= CH_ZERO && c <= CH_NINE)
                            cur_kind = TK_NUM;
                        else if (!in_quote)
                            cur_kind = TK_ID;
                        append(c);
                    end
                end
            endcase
        endfunction

        function void note_item(opcode_t op, logic [7:0] c);
            item_beats.delete();
            if (op == OP_END) begin
                close_with(cur_kind);
                close_with(TK_EOF);
                clear_state();
            end else begin
                lex_char(c);
                last_ch = c;
                seen_ch = 1'b1;
            end
            if (item_beats.size() > 0)
                item_beats[item_beats.size() - 1].last_of_run = 1'b1;
            foreach (item_beats[i])
                expected_beats.push_back(item_beats[i]);
        endfunction

        function void mismatch(string field, int unsigned exp_v, int unsigned got_v);
            if (failures < MAX_REPORTS)
                $display("[%0t] %s mismatch: expected %0d, got %0d", $time, field, exp_v, got_v);
            failures++;
        endfunction

        function void check_beat(logic [1:0] k, logic [2:0] tk, logic [7:0] c, logic e,
                                 logic last);
            lct_res_t exp_b;
            if (expected_beats.size() == 0) begin
                if (failures < MAX_REPORTS)
                    $display("[%0t] unexpected beat: expected none, got kind %0d tok %0d char %0h",
                             $time, k, tk, c);
                failures++;
                return;
            end
            exp_b = expected_beats.pop_front();
            if (k !== exp_b.kind)
                mismatch("kind", exp_b.kind, k);
            if (tk !== exp_b.token_kind)
                mismatch("token_kind", exp_b.token_kind, tk);
            if (c !== exp_b.char_out)
                mismatch("char_out", exp_b.char_out, c);
            if (e !== exp_b.error_code)
                mismatch("error_code", exp_b.error_code, e);
            if (last !== exp_b.last_of_run)
                mismatch("last_of_run", exp_b.last_of_run, last);
        endfunction

        function int outstanding();
            return expected_beats.size();
        endfunction

        function void flag_leftover();
            if (expected_beats.size() != 0) begin
                $display("[%0t] %0d expected beats never arrived, first: kind %0d tok %0d",
                         $time, expected_beats.size(), expected_beats[0].kind,
                         expected_beats[0].token_kind);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    opcode_t    opcode    = OP_CHAR;
    logic [7:0] char_in   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] kind;
    logic [2:0] token_kind;
    logic [7:0] char_out;
    logic       error_code;
    logic       last_of_run;

    always #10 clk = ~clk;

    lisp_char_tokenizer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .token_kind  (token_kind),
        .char_out    (char_out),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    tokenizer_scoreboard sb = new();

    int items_sent = 0;
    int burst_left = 0;
    int hold_ask   = 0;   // bumped by the stimulus to ask for one long hold-off

    // ------------------------------------------------------------------
    // Input side. Everything is driven with NBAs at posedge; the handshake
    // is judged at the negedge before, where all inputs and in_stall have
    // settled to what the next edge will see.
    // ------------------------------------------------------------------
    task automatic offer(opcode_t op, logic [7:0] ch);
        bit taken;
        in_valid <= 1'b1;
        opcode   <= op;
        char_in  <= ch;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        sb.note_item(op, ch);
        items_sent++;
    endtask

    // Bursts of random length with random gaps; now and then a long
    // gap-free burst.
    task automatic send_beat(src_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
        end
        burst_left--;
        offer(it.op, it.ch);
    endtask

    // Drop valid and wait for every expected beat; at least one idle edge
    // so valid is never lowered and raised in the same step.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 5))
            0, 1:    return 8'(CH_ZERO + $urandom_range(0, 9));
            2:       return 8'($urandom_range(8'h80, 8'hFF));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 2))
            0:       return SPECIALS[$urandom_range(0, 11)];
            1:       return word_char();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One source fragment: mostly well-formed tokens, strings and comments
    // with random contents, the rest noise, stray backslashes and eof.
    task automatic send_fragment();
        src_item_t frag[$];
        int        sel;
        int        n;
        sel = $urandom_range(0, 99);
        n   = $urandom_range(1, 6);
        if (sel < 20) begin
            // symbol or number
            repeat (n) frag.push_back('{OP_CHAR, word_char()});
            frag.push_back('{OP_CHAR, SPECIALS[$urandom_range(0, 2)]});
        end else if (sel < 30) begin
            frag.push_back('{OP_CHAR, $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN});
        end else if (sel < 42) begin
            // double-quoted string, escapes inside
            frag.push_back('{OP_CHAR, CH_DQUOTE});
            repeat (n) begin
                if ($urandom_range(0, 4) == 0)
                    frag.push_back('{OP_CHAR, CH_BSLASH});
                frag.push_back('{OP_CHAR, any_char()});
            end
            frag.push_back('{OP_CHAR, CH_DQUOTE});
        end else if (sel < 50) begin
            // single quote followed by whitespace, newline, a double quote, a hash or another quote
            frag.push_back('{OP_CHAR, CH_SQUOTE});
            repeat (n) frag.push_back('{OP_CHAR, word_char()});
            frag.push_back('{OP_CHAR, SPECIALS[$urandom_range(0, 5)]});
        end else if (sel < 58) begin
            frag.push_back('{OP_CHAR, CH_SEMI});
            repeat (n) frag.push_back('{OP_CHAR, any_char()});
            frag.push_back('{OP_CHAR, CH_NL});
        end else if (sel < 66) begin
            frag.push_back('{OP_CHAR, CH_HASH});
            frag.push_back('{OP_CHAR, CH_BAR});
            repeat (n) frag.push_back('{OP_CHAR, any_char()});
            frag.push_back('{OP_CHAR, CH_BAR});
            frag.push_back('{OP_CHAR, CH_HASH});
        end else if (sel < 72) begin
            frag.push_back('{OP_CHAR, CH_BSLASH});
            frag.push_back('{OP_CHAR, any_char()});
        end else if (sel < 86) begin
            frag.push_back('{OP_CHAR, SPECIALS[$urandom_range(0, 11)]});
        end else if (sel < 94) begin
            repeat (n) frag.push_back('{OP_CHAR, 8'($urandom_range(0, 255))});
        end else begin
            frag.push_back('{OP_END, 8'($urandom_range(0, 255))});
        end
        foreach (frag[i])
            send_beat(frag[i]);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern in stretches (free, random, heavy,
    // toggling), plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : stall_gen
        int hold_seen;
        int hold_left;
        int span_left;
        int mode;
        hold_seen = 0;
        hold_left = 0;
        span_left = 0;
        mode      = 0;
        forever begin
            @(posedge clk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = LONG_HOLD;
            end
            if (span_left == 0) begin
                span_left = $urandom_range(1, 40);
                mode      = $urandom_range(0, 3);
            end
            span_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= !out_stall;
                endcase
            end
        end
    end

    // Result beats are checked at the negedge before the edge that takes them
    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(kind, token_kind, char_out, error_code, last_of_run);
    end

    // Watchdog: too long without a beat on either channel means a hang
    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("[%0t] no beat for %0d cycles", $time, STALL_LIMIT);
                $display("** lisp_char_tokenizer_top: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        src_item_t directed[$];
        bit        held;
        bit        paused;
        held   = 1'b0;
        paused = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Call/end tokens, numeric and identifier kinds, string with an
        // escaped quote, stray backslash, escape inside a comment hitting
        // code, single quote closed by tab, block comment open and close,
        // zero and all-ones bytes, eof with an escape still pending.
        directed = '{
            '{OP_CHAR, CH_LPAREN}, '{OP_CHAR, 8'h61},      '{OP_CHAR, CH_NINE},
            '{OP_CHAR, CH_SPACE},  '{OP_CHAR, CH_DQUOTE},  '{OP_CHAR, CH_BSLASH},
            '{OP_CHAR, CH_DQUOTE}, '{OP_CHAR, CH_DQUOTE},  '{OP_CHAR, CH_RPAREN},
            '{OP_CHAR, CH_BSLASH}, '{OP_CHAR, CH_SEMI},    '{OP_CHAR, CH_BSLASH},
            '{OP_CHAR, 8'h71},     '{OP_CHAR, CH_NL},      '{OP_CHAR, CH_SQUOTE},
            '{OP_CHAR, CH_TAB},    '{OP_CHAR, CH_HASH},    '{OP_CHAR, CH_BAR},
            '{OP_CHAR, CH_BAR},    '{OP_CHAR, CH_HASH},    '{OP_CHAR, 8'h00},
            '{OP_CHAR, 8'hFF},     '{OP_CHAR, CH_DQUOTE},  '{OP_CHAR, CH_BSLASH},
            '{OP_END,  8'h5A}
        };
        foreach (directed[i])
            send_beat(directed[i]);
        drain();

        while (items_sent < TOTAL_ITEMS) begin
            if (!held && items_sent >= 300) begin
                // long receiver hold-off while items keep coming: the result
                // queue fills and in_stall must push back
                held = 1'b1;
                hold_ask <= hold_ask + 1;
                repeat (30) offer(OP_CHAR, $urandom_range(0, 1) ? CH_LPAREN : word_char());
                burst_left = 0;
            end
            if (!paused && items_sent >= 450) begin
                paused = 1'b1;
                drain();
            end
            send_fragment();
        end

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.flag_leftover();
        if (sb.failures == 0)
            $display("** lisp_char_tokenizer_top: PASSED **");
        else
            $display("** lisp_char_tokenizer_top: FAILED **");
        $finish;
    end

endmodule
